### design/polygon_hatch_scale_unit_assert.svh
// assertion macros for the polygon hatch scale unit
// included by polygon_hatch_scale_unit.sv, expects clk and rst_n in scope
`ifndef POLYGON_HATCH_SCALE_UNIT_ASSERT_SVH
`define POLYGON_HATCH_SCALE_UNIT_ASSERT_SVH

// condition holds at every clock edge out of reset
`define PHS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define PHS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define PHS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/phs_pkg.sv
// shared widths, constants, status codes and sequencer states of the hatch scale unit
// no dependencies; used by phs_if.sv and polygon_hatch_scale_unit.sv
package phs_pkg;

    localparam int SCALE_W   = 32;
    localparam int AREA_W    = 62;
    localparam int PERIM_W   = 40;
    localparam int LEN_W     = 26;
    localparam int TOTAL_W   = 11;
    localparam int STATUS_W  = 2;
    localparam int MAG_W     = 64;
    localparam int K_W       = 21;
    localparam int DEN_W     = 2 * PERIM_W + K_W;
    localparam int DIV_BITS  = 32;
    localparam int NUM_SHIFT = 23;
    localparam int STEP_W    = 6;

    localparam logic [LEN_W-1:0]   LEN_MAX   = '1;
    localparam logic [PERIM_W-1:0] PERIM_MAX = '1;
    // 10 * pi / phi in Q5.16
    localparam logic [K_W-1:0]     K_Q16     = 21'd1272454;
    localparam logic [SCALE_W-1:0] ONE_Q16   = 32'h0001_0000;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_DEGEN = 2'd1,
        STATUS_OVF   = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLOSE,
        ST_LOAD,
        ST_MUL,
        ST_AREA_A,
        ST_AREA_B,
        ST_SQRT,
        ST_LEN,
        ST_FINAL,
        ST_FM1,
        ST_FM2,
        ST_FM3,
        ST_FM4,
        ST_DIV_CHK,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

### design/phs_if.sv
// vertex and result channel interfaces of the hatch scale unit
// depends on phs_pkg for the result field widths
interface phs_vertex_if #(parameter int COORD_BITS = 24) ();

    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] x_coord;
    logic signed [COORD_BITS-1:0] y_coord;
    logic signed [COORD_BITS-1:0] z_coord;
    logic                         last_vertex;

    modport source (output valid, output x_coord, output y_coord, output z_coord,
                    output last_vertex, input ready);
    modport sink   (input valid, input x_coord, input y_coord, input z_coord,
                    input last_vertex, output ready);

endinterface

interface phs_result_if ();

    logic                           valid;
    logic                           ready;
    logic [phs_pkg::SCALE_W-1:0]    hatch_scale;
    logic [phs_pkg::AREA_W-1:0]     polygon_area;
    logic [phs_pkg::PERIM_W-1:0]    perimeter;
    logic [phs_pkg::LEN_W-1:0]      longest_edge;
    logic [phs_pkg::TOTAL_W-1:0]    vertex_total;
    logic [phs_pkg::STATUS_W-1:0]   status;

    modport source (output valid, output hatch_scale, output polygon_area, output perimeter,
                    output longest_edge, output vertex_total, output status, input ready);
    modport sink   (input valid, input hatch_scale, input polygon_area, input perimeter,
                    input longest_edge, input vertex_total, input status, output ready);

endinterface

### design/polygon_hatch_scale_unit.sv
// polygon hatch scale unit: shoelace area, 3d perimeter, longest edge and hatch scale
// depends on phs_pkg, phs_if.sv and polygon_hatch_scale_unit_assert.svh
//
//  channel  | role   | payload                                         | transfer
//  ---------+--------+-------------------------------------------------+-------------------
//  vertex   | sink   | x_coord, y_coord, z_coord, last_vertex           | valid & ready
//  result   | source | hatch_scale, polygon_area, perimeter,            | valid & ready
//           |        | longest_edge, vertex_total, status               |
//
//  five shift-add multipliers retire one multiplier bit per cycle for each vertex,
//  then the square root yields one root bit per cycle; no new vertex is taken meanwhile
//  the last vertex adds the closing edge, then, unless the polygon is degenerate, the bit-serial
//  numerator and denominator products and the 32-step divider run
//  reset clears the sequencer, the accumulators and the result valid flag
//  a new vertex is taken while a result waits; a finished polygon holds until the slot frees
`include "polygon_hatch_scale_unit_assert.svh"

module polygon_hatch_scale_unit #(
    parameter int MAX_VERTICES = 1024,
    parameter int COORD_BITS   = 24
) (
    input  logic         clk,
    input  logic         rst_n,
    phs_vertex_if.sink   vertex,
    phs_result_if.source result
);

    localparam int C    = COORD_BITS;
    localparam int CW   = $clog2(MAX_VERTICES + 1);
    localparam int PW2  = 2 * C;
    localparam int SQW  = 2 * C + 2;
    localparam int RW   = (SQW > 64) ? 64 : SQW;
    localparam int RH   = RW / 2;
    localparam int REMW = RH + 2;
    localparam int NL   = 5;
    localparam int SW   = phs_pkg::STEP_W;
    localparam int LW   = phs_pkg::LEN_W;
    localparam int PMW  = phs_pkg::PERIM_W;
    localparam int MW   = phs_pkg::MAG_W;
    localparam int TW   = phs_pkg::TOTAL_W;
    localparam int AW   = phs_pkg::AREA_W;
    localparam int QW   = phs_pkg::DIV_BITS;
    localparam int NSH  = phs_pkg::NUM_SHIFT;
    localparam int DROP = QW - NSH;
    localparam int NUMW = MW + LW + CW;
    localparam int FW   = (NUMW > phs_pkg::DEN_W) ? NUMW : phs_pkg::DEN_W;
    localparam int DIVW = FW + 1;
    localparam int TSW  = MW + 2;

    localparam logic [MW-1:0] INT64_MAX = {1'b0, {(MW-1){1'b1}}};
    localparam logic [MW-1:0] INT64_MIN = {1'b1, {(MW-1){1'b0}}};

    // control state
    phs_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             close_pend_reg, close_pend_next;
    logic             closed_reg, closed_next;
    logic             res_valid_reg, res_valid_next;
    logic [SW-1:0]    step_reg, step_next;
    logic [MW-1:0]    tsum_reg, tsum_next;
    logic [PMW-1:0]   lsum_reg, lsum_next;
    logic [LW-1:0]    maxlen_reg, maxlen_next;

    // vertex and edge endpoints
    logic [C-1:0] first_x_reg, first_y_reg, first_z_reg;
    logic [C-1:0] first_x_next, first_y_next, first_z_next;
    logic [C-1:0] prev_x_reg, prev_y_reg, prev_z_reg;
    logic [C-1:0] prev_x_next, prev_y_next, prev_z_next;
    logic [C-1:0] ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;
    logic [C-1:0] ax_next, ay_next, az_next, bx_next, by_next, bz_next;

    // shift-add multiplier lanes: three squared deltas and two cross products
    logic [PW2-1:0] lane_p_reg [NL];
    logic [PW2-1:0] lane_p_next [NL];
    logic [C-1:0]   lane_mc_reg [NL];
    logic [C-1:0]   lane_mc_next [NL];
    logic [C:0]     lane_sum [NL];
    logic           p1neg_reg, p1neg_next, p2neg_reg, p2neg_next;

    // square root
    logic [RW-1:0]   rad_reg, rad_next;
    logic [REMW-1:0] rem_reg, rem_next;
    logic [RH-1:0]   root_reg, root_next;

    // final products and divider
    logic [FW-1:0]   fin_p_reg, fin_p_next, fin_mc_reg, fin_mc_next;
    logic [PMW-1:0]  fin_mp_reg, fin_mp_next;
    logic [FW-1:0]   den_reg, den_next;
    logic [DIVW-1:0] div_rem_reg, div_rem_next;
    logic [QW-1:0]   div_lo_reg, div_lo_next;
    logic [QW-1:0]   quo_reg, quo_next;

    // result slot
    logic [phs_pkg::SCALE_W-1:0] res_scale_reg, res_scale_next;
    logic [AW-1:0]               res_area_reg, res_area_next;
    logic [PMW-1:0]              res_perim_reg, res_perim_next;
    logic [LW-1:0]               res_longest_reg, res_longest_next;
    logic [TW-1:0]               res_total_reg, res_total_next;
    phs_pkg::status_t            res_status_reg, res_status_next;

    // datapath terms
    logic            in_fire;
    logic [C:0]      dx, dy, dz, dx_mag, dy_mag, dz_mag;
    logic [C:0]      ax_mag, ay_mag, bx_mag, by_mag;
    logic [PW2-1:0]  area_p;
    logic            area_neg;
    logic [TSW-1:0]  area_ext, area_add, area_sum;
    logic [MW-1:0]   area_sat;
    logic [SQW-1:0]  sumsq;
    logic [RW-1:0]   rad_init;
    logic [REMW+1:0] rem_sh, trial, sq_diff;
    logic            sq_ge;
    logic [31:0]     root32;
    logic [LW-1:0]   edge_len;
    logic [PMW:0]    lsum_add;
    logic [PMW-1:0]  lsum_sat;
    logic [FW-1:0]   fin_sum;
    logic [DIVW-1:0] den_ext, div_sh, div_diff;
    logic            div_ge;
    logic [MW-1:0]   t_abs, mag;
    logic [AW-1:0]   area_out;
    logic            degen;
    phs_pkg::status_t status_now;

    function automatic logic [C:0] mag_of(input logic [C:0] v);
        mag_of = v[C] ? (~v + 1'b1) : v;
    endfunction

    assign in_fire      = vertex.valid && vertex.ready;
    assign vertex.ready = (state_reg == phs_pkg::ST_IDLE);

    assign result.valid        = res_valid_reg;
    assign result.hatch_scale  = res_scale_reg;
    assign result.polygon_area = res_area_reg;
    assign result.perimeter    = res_perim_reg;
    assign result.longest_edge = res_longest_reg;
    assign result.vertex_total = res_total_reg;
    assign result.status       = res_status_reg;

    // edge deltas and operand magnitudes
    assign dx     = {bx_reg[C-1], bx_reg} - {ax_reg[C-1], ax_reg};
    assign dy     = {by_reg[C-1], by_reg} - {ay_reg[C-1], ay_reg};
    assign dz     = {bz_reg[C-1], bz_reg} - {az_reg[C-1], az_reg};
    assign dx_mag = mag_of(dx);
    assign dy_mag = mag_of(dy);
    assign dz_mag = mag_of(dz);
    assign ax_mag = mag_of({ax_reg[C-1], ax_reg});
    assign ay_mag = mag_of({ay_reg[C-1], ay_reg});
    assign bx_mag = mag_of({bx_reg[C-1], bx_reg});
    assign by_mag = mag_of({by_reg[C-1], by_reg});

    // saturating twice-area accumulate, x0*y1 first, then minus x1*y0
    assign area_p   = (state_reg == phs_pkg::ST_AREA_A) ? lane_p_reg[3] : lane_p_reg[4];
    assign area_neg = (state_reg == phs_pkg::ST_AREA_A) ? p1neg_reg : !p2neg_reg;
    assign area_ext = TSW'(area_p);
    assign area_add = area_neg ? (~area_ext + 1'b1) : area_ext;
    assign area_sum = {{2{tsum_reg[MW-1]}}, tsum_reg} + area_add;

    always_comb
    begin
        priority if (area_sum[TSW-1:MW-1] == 3'b000 || area_sum[TSW-1:MW-1] == 3'b111)
            area_sat = area_sum[MW-1:0];
        else if (!area_sum[TSW-1])
            area_sat = INT64_MAX;
        else
            area_sat = INT64_MIN;
    end

    // sum of squares, clamped to 64 bits
    assign sumsq    = SQW'(lane_p_reg[0]) + SQW'(lane_p_reg[1]) + SQW'(lane_p_reg[2]);
    assign rad_init = (sumsq > SQW'({MW{1'b1}})) ? {RW{1'b1}} : RW'(sumsq);

    // one root bit per cycle
    assign rem_sh  = {rem_reg, rad_reg[RW-1:RW-2]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign sq_ge   = (rem_sh >= trial);
    assign sq_diff = rem_sh - trial;

    assign root32   = 32'(root_reg);
    assign edge_len = (root32 > 32'(phs_pkg::LEN_MAX)) ? phs_pkg::LEN_MAX : root32[LW-1:0];
    assign lsum_add = {1'b0, lsum_reg} + (PMW + 1)'(edge_len);
    assign lsum_sat = (lsum_add > (PMW + 1)'(phs_pkg::PERIM_MAX)) ? phs_pkg::PERIM_MAX
                                                                  : lsum_add[PMW-1:0];

    // final shift-add product, one multiplier bit per cycle
    assign fin_sum = fin_p_reg + (fin_mp_reg[0] ? fin_mc_reg : '0);

    // restoring divider, quotient msb first
    assign den_ext  = DIVW'(den_reg);
    assign div_sh   = {div_rem_reg[DIVW-2:0], div_lo_reg[QW-1]};
    assign div_ge   = (div_sh >= den_ext);
    assign div_diff = div_sh - den_ext;

    // closing results
    assign t_abs    = tsum_reg[MW-1] ? (~tsum_reg + 1'b1) : tsum_reg;
    assign mag      = (count_reg < CW'(3)) ? '0 : t_abs;
    assign area_out = mag[MW-1] ? {AW{1'b1}} : mag[AW:1];
    assign degen    = (count_reg < CW'(2)) || (lsum_reg == '0);

    always_comb
    begin
        priority if (ovf_reg)
            status_now = phs_pkg::STATUS_OVF;
        else if (degen)
            status_now = phs_pkg::STATUS_DEGEN;
        else
            status_now = phs_pkg::STATUS_OK;
    end

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        ovf_next         = ovf_reg;
        close_pend_next  = close_pend_reg;
        closed_next      = closed_reg;
        res_valid_next   = res_valid_reg;
        step_next        = step_reg;
        tsum_next        = tsum_reg;
        lsum_next        = lsum_reg;
        maxlen_next      = maxlen_reg;
        first_x_next     = first_x_reg;
        first_y_next     = first_y_reg;
        first_z_next     = first_z_reg;
        prev_x_next      = prev_x_reg;
        prev_y_next      = prev_y_reg;
        prev_z_next      = prev_z_reg;
        ax_next          = ax_reg;
        ay_next          = ay_reg;
        az_next          = az_reg;
        bx_next          = bx_reg;
        by_next          = by_reg;
        bz_next          = bz_reg;
        lane_p_next      = lane_p_reg;
        lane_mc_next     = lane_mc_reg;
        p1neg_next       = p1neg_reg;
        p2neg_next       = p2neg_reg;
        rad_next         = rad_reg;
        rem_next         = rem_reg;
        root_next        = root_reg;
        fin_p_next       = fin_p_reg;
        fin_mc_next      = fin_mc_reg;
        fin_mp_next      = fin_mp_reg;
        den_next         = den_reg;
        div_rem_next     = div_rem_reg;
        div_lo_next      = div_lo_reg;
        quo_next         = quo_reg;
        res_scale_next   = res_scale_reg;
        res_area_next    = res_area_reg;
        res_perim_next   = res_perim_reg;
        res_longest_next = res_longest_reg;
        res_total_next   = res_total_reg;
        res_status_next  = res_status_reg;

        if (result.ready)
            res_valid_next = 1'b0;

        for (int l = 0; l < NL; l++)
        begin
            lane_sum[l] = {1'b0, lane_p_reg[l][PW2-1:C]}
                        + (lane_p_reg[l][0] ? {1'b0, lane_mc_reg[l]} : '0);
        end

        unique case (state_reg)
            phs_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    prev_x_next     = vertex.x_coord;
                    prev_y_next     = vertex.y_coord;
                    prev_z_next     = vertex.z_coord;
                    ax_next         = prev_x_reg;
                    ay_next         = prev_y_reg;
                    az_next         = prev_z_reg;
                    bx_next         = vertex.x_coord;
                    by_next         = vertex.y_coord;
                    bz_next         = vertex.z_coord;
                    close_pend_next = vertex.last_vertex;
                    if (count_reg < CW'(MAX_VERTICES))
                        count_next = count_reg + 1'b1;
                    else
                        ovf_next = 1'b1;
                    if (count_reg == '0)
                    begin
                        // first vertex opens the polygon, no edge yet
                        first_x_next = vertex.x_coord;
                        first_y_next = vertex.y_coord;
                        first_z_next = vertex.z_coord;
                        state_next   = vertex.last_vertex ? phs_pkg::ST_CLOSE
                                                          : phs_pkg::ST_IDLE;
                    end
                    else
                        state_next = phs_pkg::ST_LOAD;
                end
            end

            phs_pkg::ST_CLOSE:
            begin
                ax_next         = prev_x_reg;
                ay_next         = prev_y_reg;
                az_next         = prev_z_reg;
                bx_next         = first_x_reg;
                by_next         = first_y_reg;
                bz_next         = first_z_reg;
                close_pend_next = 1'b0;
                closed_next     = 1'b1;
                state_next      = phs_pkg::ST_LOAD;
            end

            phs_pkg::ST_LOAD:
            begin
                lane_mc_next[0] = dx_mag[C-1:0];
                lane_p_next[0]  = PW2'(dx_mag[C-1:0]);
                lane_mc_next[1] = dy_mag[C-1:0];
                lane_p_next[1]  = PW2'(dy_mag[C-1:0]);
                lane_mc_next[2] = dz_mag[C-1:0];
                lane_p_next[2]  = PW2'(dz_mag[C-1:0]);
                lane_mc_next[3] = ax_mag[C-1:0];
                lane_p_next[3]  = PW2'(by_mag[C-1:0]);
                lane_mc_next[4] = bx_mag[C-1:0];
                lane_p_next[4]  = PW2'(ay_mag[C-1:0]);
                p1neg_next      = ax_reg[C-1] ^ by_reg[C-1];
                p2neg_next      = bx_reg[C-1] ^ ay_reg[C-1];
                step_next       = SW'(C - 1);
                state_next      = phs_pkg::ST_MUL;
            end

            phs_pkg::ST_MUL:
            begin
                for (int l = 0; l < NL; l++)
                    lane_p_next[l] = {lane_sum[l], lane_p_reg[l][C-1:1]};
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                    state_next = phs_pkg::ST_AREA_A;
            end

            phs_pkg::ST_AREA_A:
            begin
                tsum_next  = area_sat;
                rad_next   = rad_init;
                rem_next   = '0;
                root_next  = '0;
                step_next  = SW'(RH - 1);
                state_next = phs_pkg::ST_AREA_B;
            end

            phs_pkg::ST_AREA_B:
            begin
                tsum_next  = area_sat;
                state_next = phs_pkg::ST_SQRT;
            end

            phs_pkg::ST_SQRT:
            begin
                rad_next  = {rad_reg[RW-3:0], 2'b00};
                rem_next  = sq_ge ? sq_diff[REMW-1:0] : rem_sh[REMW-1:0];
                root_next = {root_reg[RH-2:0], sq_ge};
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                    state_next = phs_pkg::ST_LEN;
            end

            phs_pkg::ST_LEN:
            begin
                lsum_next = lsum_sat;
                if (edge_len > maxlen_reg)
                    maxlen_next = edge_len;
                priority if (close_pend_reg)
                    state_next = phs_pkg::ST_CLOSE;
                else if (closed_reg)
                    state_next = phs_pkg::ST_FINAL;
                else
                    state_next = phs_pkg::ST_IDLE;
            end

            phs_pkg::ST_FINAL:
            begin
                if (degen)
                begin
                    quo_next   = phs_pkg::ONE_Q16;
                    state_next = phs_pkg::ST_DONE;
                end
                else
                begin
                    // |T| * longest edge
                    fin_p_next  = '0;
                    fin_mc_next = FW'(mag);
                    fin_mp_next = PMW'(maxlen_reg);
                    step_next   = SW'(LW - 1);
                    state_next  = phs_pkg::ST_FM1;
                end
            end

            phs_pkg::ST_FM1:
            begin
                fin_p_next  = fin_sum;
                fin_mc_next = {fin_mc_reg[FW-2:0], 1'b0};
                fin_mp_next = {1'b0, fin_mp_reg[PMW-1:1]};
                step_next   = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    // times vertex count
                    fin_p_next  = '0;
                    fin_mc_next = fin_sum;
                    fin_mp_next = PMW'(count_reg);
                    step_next   = SW'(CW - 1);
                    state_next  = phs_pkg::ST_FM2;
                end
            end

            phs_pkg::ST_FM2:
            begin
                fin_p_next  = fin_sum;
                fin_mc_next = {fin_mc_reg[FW-2:0], 1'b0};
                fin_mp_next = {1'b0, fin_mp_reg[PMW-1:1]};
                step_next   = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    // numerator scaled by 2^23 splits into divider high part and low bits
                    div_rem_next = DIVW'(fin_sum >> DROP);
                    div_lo_next  = {fin_sum[DROP-1:0], {NSH{1'b0}}};
                    fin_p_next   = '0;
                    fin_mc_next  = FW'(lsum_reg);
                    fin_mp_next  = lsum_reg;
                    step_next    = SW'(PMW - 1);
                    state_next   = phs_pkg::ST_FM3;
                end
            end

            phs_pkg::ST_FM3:
            begin
                fin_p_next  = fin_sum;
                fin_mc_next = {fin_mc_reg[FW-2:0], 1'b0};
                fin_mp_next = {1'b0, fin_mp_reg[PMW-1:1]};
                step_next   = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    fin_p_next  = '0;
                    fin_mc_next = fin_sum;
                    fin_mp_next = PMW'(phs_pkg::K_Q16);
                    step_next   = SW'(phs_pkg::K_W - 1);
                    state_next  = phs_pkg::ST_FM4;
                end
            end

            phs_pkg::ST_FM4:
            begin
                fin_p_next  = fin_sum;
                fin_mc_next = {fin_mc_reg[FW-2:0], 1'b0};
                fin_mp_next = {1'b0, fin_mp_reg[PMW-1:1]};
                step_next   = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    den_next   = fin_sum;
                    state_next = phs_pkg::ST_DIV_CHK;
                end
            end

            phs_pkg::ST_DIV_CHK:
            begin
                // quotient of 2^32 or more saturates
                if (div_rem_reg >= den_ext)
                begin
                    quo_next   = '1;
                    state_next = phs_pkg::ST_DONE;
                end
                else
                begin
                    quo_next   = '0;
                    step_next  = SW'(QW - 1);
                    state_next = phs_pkg::ST_DIV;
                end
            end

            phs_pkg::ST_DIV:
            begin
                div_rem_next = div_ge ? div_diff : div_sh;
                div_lo_next  = {div_lo_reg[QW-2:0], 1'b0};
                quo_next     = {quo_reg[QW-2:0], div_ge};
                step_next    = step_reg - 1'b1;
                if (step_reg == '0)
                    state_next = phs_pkg::ST_DONE;
            end

            phs_pkg::ST_DONE:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    res_valid_next   = 1'b1;
                    res_scale_next   = quo_reg;
                    res_area_next    = area_out;
                    res_perim_next   = lsum_reg;
                    res_longest_next = maxlen_reg;
                    res_total_next   = TW'(count_reg);
                    res_status_next  = status_now;
                    count_next       = '0;
                    ovf_next         = 1'b0;
                    closed_next      = 1'b0;
                    tsum_next        = '0;
                    lsum_next        = '0;
                    maxlen_next      = '0;
                    state_next       = phs_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= phs_pkg::ST_IDLE;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            close_pend_reg <= 1'b0;
            closed_reg     <= 1'b0;
            res_valid_reg  <= 1'b0;
            step_reg       <= '0;
            tsum_reg       <= '0;
            lsum_reg       <= '0;
            maxlen_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            close_pend_reg <= close_pend_next;
            closed_reg     <= closed_next;
            res_valid_reg  <= res_valid_next;
            step_reg       <= step_next;
            tsum_reg       <= tsum_next;
            lsum_reg       <= lsum_next;
            maxlen_reg     <= maxlen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_x_reg     <= first_x_next;
        first_y_reg     <= first_y_next;
        first_z_reg     <= first_z_next;
        prev_x_reg      <= prev_x_next;
        prev_y_reg      <= prev_y_next;
        prev_z_reg      <= prev_z_next;
        ax_reg          <= ax_next;
        ay_reg          <= ay_next;
        az_reg          <= az_next;
        bx_reg          <= bx_next;
        by_reg          <= by_next;
        bz_reg          <= bz_next;
        lane_p_reg      <= lane_p_next;
        lane_mc_reg     <= lane_mc_next;
        p1neg_reg       <= p1neg_next;
        p2neg_reg       <= p2neg_next;
        rad_reg         <= rad_next;
        rem_reg         <= rem_next;
        root_reg        <= root_next;
        fin_p_reg       <= fin_p_next;
        fin_mc_reg      <= fin_mc_next;
        fin_mp_reg      <= fin_mp_next;
        den_reg         <= den_next;
        div_rem_reg     <= div_rem_next;
        div_lo_reg      <= div_lo_next;
        quo_reg         <= quo_next;
        res_scale_reg   <= res_scale_next;
        res_area_reg    <= res_area_next;
        res_perim_reg   <= res_perim_next;
        res_longest_reg <= res_longest_next;
        res_total_reg   <= res_total_next;
        res_status_reg  <= res_status_next;
    end

    `PHS_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(MAX_VERTICES),
        "vertex count past bound")
    `PHS_ASSERT_IMPL(a_div_rem_bound, state_reg == phs_pkg::ST_DIV,
        div_rem_reg < den_ext, "divider remainder not below denominator")
    `PHS_ASSERT_NEXT(a_done_clears,
        state_reg == phs_pkg::ST_DONE && (!res_valid_reg || result.ready),
        count_reg == '0 && res_valid_reg && state_reg == phs_pkg::ST_IDLE,
        "result load did not clear polygon state")
    `PHS_ASSERT_IMPL(a_degen_scale,
        result.valid && result.status == phs_pkg::STATUS_DEGEN,
        result.hatch_scale == phs_pkg::ONE_Q16, "degenerate result without unit scale")

endmodule
